// File: rtl/api_frame_receiver_assert.svh
// Assertion macros used by the frame receiver top level.
`ifndef API_FRAME_RECEIVER_ASSERT_SVH
`define API_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARF_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARF_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/arf_pkg.sv
// Types and constants of the frame receiver.
package arf_pkg;

	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 1'b1;

	localparam logic [7:0] MIN_LENGTH_RESET = 8'd5;
	localparam logic [7:0] MAX_LENGTH_RESET = 8'd40;

	localparam logic [7:0] START_BYTE    = 8'h7e;
	localparam logic [7:0] KIND_STATUS   = 8'h8b;
	localparam logic [7:0] KIND_MODEM    = 8'h8a;
	localparam logic [7:0] KIND_RX_DATA  = 8'h90;
	localparam logic [7:0] CHECKSUM_GOOD = 8'hff;

	localparam logic [7:0] OFS_KIND     = 8'd0;
	localparam logic [7:0] OFS_TAG      = 8'd1;
	localparam logic [7:0] OFS_DELIVERY = 8'd5;
	localparam logic [7:0] OFS_PAYLOAD  = 8'd12;

	localparam logic [1:0] ST_GOOD  = 2'd0;
	localparam logic [1:0] ST_LEN   = 2'd1;
	localparam logic [1:0] ST_CSUM  = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [2:0] CLS_OTHER   = 3'd0;
	localparam logic [2:0] CLS_ACK     = 3'd1;
	localparam logic [2:0] CLS_NACK    = 3'd2;
	localparam logic [2:0] CLS_MODEM   = 3'd3;
	localparam logic [2:0] CLS_RX_DATA = 3'd4;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       gap;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  frame_class;
		logic [7:0]  frame_kind;
		logic [7:0]  frame_tag;
		logic [15:0] frame_size;
		logic [7:0]  delivery_code;
		logic [7:0]  first_payload;
	} result_t;

	typedef struct packed {
		logic [7:0] min_length;
		logic [7:0] max_length;
	} cfg_t;

endpackage

// File: rtl/api_frame_receiver.sv
// Top level of the frame receiver: input register, deframer and result register.
// Takes one received byte (or a line gap marker) per transaction and reports each
// finished, rejected or truncated frame as one result transaction. One input
// transaction is accepted every cycle unless the input channel stalls; a byte is
// registered in the input register and its result, if any, is then registered
// in the result register. The only stall comes from the result side:
// when the result register is full and stalled while the input register holds a
// transaction, that transaction waits and the input channel stalls; with the
// input register empty, one more transaction is still taken. Configuration
// writes take effect at once and are meant to be made while no frame is in
// progress.
`include "api_frame_receiver_assert.svh"

module api_frame_receiver (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  arf_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output arf_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [arf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);

	arf_pkg::cfg_t    cfg;
	arf_pkg::item_t   item_s1;
	logic             item_valid_s1;
	logic             proceed;
	logic             emit;
	arf_pkg::result_t res;
	arf_pkg::result_t result_q;
	logic             result_valid_q;

	arf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign proceed    = item_valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = item_valid_s1 && result_valid_q && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	arf_deframer u_deframer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (proceed),
		.item   (item_s1),
		.cfg    (cfg),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (proceed && emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && emit)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ARF_ASSERT_IMP(a_no_overwrite, clk, arst_n, proceed && emit,
		!result_valid_q || !result_stall, "result register overwritten while stalled")
	`ARF_ASSERT_IMP(a_stall_needs_item, clk, arst_n, item_stall,
		item_valid_s1 && result_valid_q, "input stalled with no held transaction")
	`ARF_ASSERT_NXT(a_accept_lands, clk, arst_n, item_valid && !item_stall,
		item_valid_s1, "accepted transaction lost from input register")
	`ARF_ASSERT_IMP(a_bad_is_other, clk, arst_n,
		result_valid_q && result_q.status != arf_pkg::ST_GOOD,
		result_q.frame_class == arf_pkg::CLS_OTHER, "bad frame carries a class")

endmodule

// File: rtl/arf_cfg_regs.sv
// Configuration registers of the frame receiver.
module arf_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [arf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	output arf_pkg::cfg_t                   cfg
);

	arf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length <= arf_pkg::MIN_LENGTH_RESET;
			cfg_q.max_length <= arf_pkg::MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				arf_pkg::CFG_MIN_LENGTH: cfg_q.min_length <= cfg_data;
				arf_pkg::CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/arf_deframer.sv
// Frame state machine: length check, running checksum and field capture.
module arf_deframer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  arf_pkg::item_t    item,
	input  arf_pkg::cfg_t     cfg,
	output logic              emit,
	output arf_pkg::result_t  res
);

	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_LEN_HI  = 6'b000010,
		PH_LEN_LO  = 6'b000100,
		PH_DATA    = 6'b001000,
		PH_CSUM    = 6'b010000,
		PH_DISCARD = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [15:0] length_q, length_n;
	logic [7:0]  count_q, count_n;
	logic [7:0]  sum_q, sum_n;
	logic [7:0]  kind_q, kind_n;
	logic [7:0]  tag_q, tag_n;
	logic [7:0]  deliv_q, deliv_n;
	logic [7:0]  pay_q, pay_n;
	logic [1:0]  st;
	logic [15:0] len_full;
	logic [7:0]  sum_csum;
	logic [2:0]  cls;

	always_comb begin
		phase_n  = phase_q;
		length_n = length_q;
		count_n  = count_q;
		sum_n    = sum_q;
		kind_n   = kind_q;
		tag_n    = tag_q;
		deliv_n  = deliv_q;
		pay_n    = pay_q;
		emit     = 1'b0;
		st       = arf_pkg::ST_GOOD;
		len_full = {length_q[15:8], item.rx_byte};
		sum_csum = sum_q + item.rx_byte;
		if (item.gap) begin
			if (phase_q == PH_LEN_HI || phase_q == PH_LEN_LO ||
			    phase_q == PH_DATA || phase_q == PH_CSUM) begin
				emit = 1'b1;
				st   = arf_pkg::ST_TRUNC;
			end
			phase_n = PH_HUNT;
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (item.rx_byte == arf_pkg::START_BYTE) begin
						length_n = '0;
						count_n  = '0;
						sum_n    = '0;
						kind_n   = '0;
						tag_n    = '0;
						deliv_n  = '0;
						pay_n    = '0;
						phase_n  = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					length_n = {item.rx_byte, 8'h00};
					phase_n  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					length_n = len_full;
					if (len_full < {8'h00, cfg.min_length} ||
					    len_full > {8'h00, cfg.max_length}) begin
						emit    = 1'b1;
						st      = arf_pkg::ST_LEN;
						phase_n = PH_DISCARD;
					end else begin
						count_n = '0;
						sum_n   = '0;
						phase_n = (len_full == 16'h0000) ? PH_CSUM : PH_DATA;
					end
				end
				PH_DATA: begin
					sum_n = sum_csum;
					if (count_q == arf_pkg::OFS_KIND)
						kind_n = item.rx_byte;
					else if (count_q == arf_pkg::OFS_TAG)
						tag_n = item.rx_byte;
					else if (count_q == arf_pkg::OFS_DELIVERY)
						deliv_n = item.rx_byte;
					else if (count_q == arf_pkg::OFS_PAYLOAD)
						pay_n = item.rx_byte;
					count_n = count_q + 8'd1;
					if ({8'h00, count_n} >= length_q)
						phase_n = PH_CSUM;
				end
				PH_CSUM: begin
					emit    = 1'b1;
					st      = (sum_csum == arf_pkg::CHECKSUM_GOOD) ?
					          arf_pkg::ST_GOOD : arf_pkg::ST_CSUM;
					phase_n = PH_HUNT;
				end
				PH_DISCARD: begin
					phase_n = PH_DISCARD;
				end
				default: begin
					phase_n = PH_HUNT;
				end
			endcase
		end
	end

	always_comb begin
		if (kind_n == arf_pkg::KIND_STATUS)
			cls = (deliv_n == 8'h00) ? arf_pkg::CLS_ACK : arf_pkg::CLS_NACK;
		else if (kind_n == arf_pkg::KIND_MODEM)
			cls = arf_pkg::CLS_MODEM;
		else if (kind_n == arf_pkg::KIND_RX_DATA)
			cls = arf_pkg::CLS_RX_DATA;
		else
			cls = arf_pkg::CLS_OTHER;
	end

	assign res.status        = st;
	assign res.frame_class   = (st == arf_pkg::ST_GOOD) ? cls : arf_pkg::CLS_OTHER;
	assign res.frame_kind    = kind_n;
	assign res.frame_tag     = tag_n;
	assign res.frame_size    = length_n;
	assign res.delivery_code = deliv_n;
	assign res.first_payload = pay_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			length_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			kind_q   <= '0;
			tag_q    <= '0;
			deliv_q  <= '0;
			pay_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			length_q <= length_n;
			count_q  <= count_n;
			sum_q    <= sum_n;
			kind_q   <= kind_n;
			tag_q    <= tag_n;
			deliv_q  <= deliv_n;
			pay_q    <= pay_n;
		end
	end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the API frame receiver with a transaction-level frame predictor.
`timescale 1ns / 100ps

module tb_top;
	import arf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int N_SETTINGS  = 8;

	class frame_checker;
		typedef enum logic [2:0] {HUNT, LEN_HI, LEN_LO, DATA, CSUM, DISCARD} phase_e;

		phase_e      phase;
		logic [15:0] length_word;
		logic [7:0]  byte_count;
		logic [7:0]  running_sum;
		logic [7:0]  kind_q;
		logic [7:0]  tag_q;
		logic [7:0]  delivery_q;
		logic [7:0]  payload_q;
		logic [7:0]  min_len;
		logic [7:0]  max_len;
		result_t     expected_frames[$];
		int          errors;
		int          results_seen;
		int          status_seen[4];

		function new();
			min_len = MIN_LENGTH_RESET;
			max_len = MAX_LENGTH_RESET;
			phase = HUNT;
			length_word = '0;
			byte_count = '0;
			running_sum = '0;
			kind_q = '0;
			tag_q = '0;
			delivery_q = '0;
			payload_q = '0;
			errors = 0;
			results_seen = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] value);
			if (idx == CFG_MIN_LENGTH) begin
				min_len = value;
			end else if (idx == CFG_MAX_LENGTH) begin
				max_len = value;
			end
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function result_t frame_result(logic [1:0] st);
			result_t r;
			r.status = st;
			r.frame_class = CLS_OTHER;
			if (st == ST_GOOD) begin
				if (kind_q == KIND_STATUS) begin
					r.frame_class = (delivery_q == 8'd0) ? CLS_ACK : CLS_NACK;
				end else if (kind_q == KIND_MODEM) begin
					r.frame_class = CLS_MODEM;
				end else if (kind_q == KIND_RX_DATA) begin
					r.frame_class = CLS_RX_DATA;
				end
			end
			r.frame_kind = kind_q;
			r.frame_tag = tag_q;
			r.frame_size = length_word;
			r.delivery_code = delivery_q;
			r.first_payload = payload_q;
			return r;
		endfunction

		function void note_item(item_t it);
			logic [7:0] b;
			logic [7:0] total;
			b = it.rx_byte;
			if (it.gap) begin
				if (phase inside {LEN_HI, LEN_LO, DATA, CSUM}) begin
					expected_frames.push_back(frame_result(ST_TRUNC));
				end
				phase = HUNT;
				return;
			end
			case (phase)
				HUNT: begin
					if (b == START_BYTE) begin
						length_word = '0;
						byte_count = '0;
						running_sum = '0;
						kind_q = '0;
						tag_q = '0;
						delivery_q = '0;
						payload_q = '0;
						phase = LEN_HI;
					end
				end
				LEN_HI: begin
					length_word = {b, 8'h00};
					phase = LEN_LO;
				end
				LEN_LO: begin
					length_word[7:0] = b;
					if (length_word < {8'h00, min_len} || length_word > {8'h00, max_len}) begin
						expected_frames.push_back(frame_result(ST_LEN));
						phase = DISCARD;
					end else begin
						byte_count = '0;
						running_sum = '0;
						phase = (length_word == 16'd0) ? CSUM : DATA;
					end
				end
				DATA: begin
					running_sum = running_sum + b;
					if (byte_count == OFS_KIND) begin
						kind_q = b;
					end else if (byte_count == OFS_TAG) begin
						tag_q = b;
					end else if (byte_count == OFS_DELIVERY) begin
						delivery_q = b;
					end else if (byte_count == OFS_PAYLOAD) begin
						payload_q = b;
					end
					byte_count = byte_count + 8'd1;
					if ({8'h00, byte_count} >= length_word) phase = CSUM;
				end
				CSUM: begin
					total = running_sum + b;
					expected_frames.push_back(frame_result((total == CHECKSUM_GOOD) ? ST_GOOD : ST_CSUM));
					phase = HUNT;
				end
				default: begin
				end
			endcase
		endfunction

		function string fmt(result_t r);
			return $sformatf("status %0d class %0d kind %h tag %h size %h delivery %h payload %h",
				r.status, r.frame_class, r.frame_kind, r.frame_tag, r.frame_size,
				r.delivery_code, r.first_payload);
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			status_seen[got.status]++;
			if (expected_frames.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR unexpected result: %s", fmt(got));
				return;
			end
			want = expected_frames.pop_front();
			if (got.status !== want.status || got.frame_class !== want.frame_class ||
					got.frame_kind !== want.frame_kind || got.frame_tag !== want.frame_tag ||
					got.frame_size !== want.frame_size ||
					got.delivery_code !== want.delivery_code ||
					got.first_payload !== want.first_payload) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR result mismatch");
					$display("  expected %s", fmt(want));
					$display("  actual   %s", fmt(got));
				end
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	item_t                  item;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]             cfg_data;

	frame_checker sb;
	int           items_sent;
	int           src_rate;
	int           sink_rate;
	int           cur_min;
	int           cur_max;
	bit           hold_off_req;

	api_frame_receiver u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
	end

	initial begin : result_sink
		int hold;
		hold = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold = 80;
			end else if (hold == 0 && sink_rate > 0 && $urandom_range(0, 99) < sink_rate) begin
				hold = $urandom_range(1, 15);
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	task automatic send_item(item_t it);
		int idle;
		idle = 0;
		if (src_rate > 0 && $urandom_range(0, 99) < src_rate) idle = $urandom_range(1, 15);
		@(negedge clk);
		if (idle > 0) begin
			item_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		item_t it;
		it.rx_byte = b;
		it.gap = 1'b0;
		send_item(it);
	endtask

	task automatic send_gap();
		item_t it;
		it.rx_byte = 8'($urandom_range(0, 255));
		it.gap = 1'b1;
		send_item(it);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// A negative cut sends the whole frame; else a gap replaces data byte cut (checksum at len).
	task automatic send_frame(logic [15:0] len, logic [7:0] kind, bit bad_sum, int cut);
		logic [7:0] sum;
		logic [7:0] b;
		sum = '0;
		send_byte(START_BYTE);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		for (int i = 0; i < len; i++) begin
			if (i == cut) begin
				send_gap();
				return;
			end
			b = (i == 0) ? kind : 8'($urandom_range(0, 255));
			if (i == 5 && kind == KIND_STATUS && $urandom_range(0, 1) == 1) b = 8'h00;
			sum = sum + b;
			send_byte(b);
		end
		if (cut == int'(len)) begin
			send_gap();
			return;
		end
		b = CHECKSUM_GOOD - sum;
		if (bad_sum) b = b + 8'($urandom_range(1, 255));
		send_byte(b);
	endtask

	task automatic send_random_frame();
		int         r;
		int         top;
		int         cut;
		logic [15:0] len;
		logic [7:0]  kind;
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 4))
			0: kind = KIND_STATUS;
			1: kind = KIND_MODEM;
			2: kind = KIND_RX_DATA;
			3: kind = START_BYTE;
			default: kind = 8'($urandom_range(0, 255));
		endcase
		if (r < 65 && cur_min <= cur_max) begin
			top = (cur_min + 16 < cur_max) ? cur_min + 16 : cur_max;
			if ($urandom_range(0, 4) == 0) begin
				len = 16'($urandom_range(cur_min, cur_max));
			end else begin
				len = 16'($urandom_range(cur_min, top));
			end
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
			send_frame(len, kind, $urandom_range(0, 6) == 0, cut);
		end else if (r < 82) begin
			do begin
				if ($urandom_range(0, 1) == 1) begin
					len = 16'($urandom_range(0, 300));
				end else begin
					len = 16'($urandom_range(0, 65535));
				end
			end while (len >= cur_min && len <= cur_max);
			cut = $urandom_range(0, (len < 6) ? len : 6);
			send_frame(len, kind, 1'b0, cut);
		end else if (r < 90) begin
			send_byte(START_BYTE);
			if ($urandom_range(0, 1) == 1) send_byte(8'($urandom_range(0, 255)));
			send_gap();
		end else begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			send_gap();
		end
	endtask

	initial begin : stimulus
		int directed_seq[21] = '{
			-1, 8'h00, 8'hff,
			8'h7e, 8'h00, 8'h06, 8'h8b, 8'h7e, 8'h00, 8'h00, 8'h00, 8'h00, 8'hf6,
			8'h7e, 8'h00, 8'h03, 8'h7e, -1,
			8'h7e, 8'h12, -1
		};
		int min_table[N_SETTINGS]  = '{0, 1, 0, 255, 200, 0, 12, 5};
		int max_table[N_SETTINGS]  = '{255, 1, 0, 255, 10, 20, 14, 40};
		int src_table[N_SETTINGS]  = '{10, 0, 30, 5, 20, 15, 10, 0};
		int sink_table[N_SETTINGS] = '{10, 30, 0, 10, 20, 5, 15, 0};
		int budget;

		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_sent = 0;
		src_rate = 0;
		sink_rate = 0;
		hold_off_req = 1'b0;
		cur_min = MIN_LENGTH_RESET;
		cur_max = MAX_LENGTH_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Ack frame with a start byte inside its data, a short frame whose tail is
		// discarded, and a gap while the length is arriving.
		foreach (directed_seq[i]) begin
			if (directed_seq[i] < 0) begin
				send_gap();
			end else begin
				send_byte(8'(directed_seq[i]));
			end
		end

		for (int p = 0; p < N_SETTINGS; p++) begin
			send_gap();
			drain();
			write_reg(CFG_MIN_LENGTH, 8'(min_table[p]));
			write_reg(CFG_MAX_LENGTH, 8'(max_table[p]));
			cur_min = min_table[p];
			cur_max = max_table[p];
			src_rate = src_table[p];
			sink_rate = sink_table[p];
			if (p == 2) hold_off_req = 1'b1;
			budget = items_sent + ((cur_min == 255) ? 550 : 220);
			while (items_sent < budget) send_random_frame();
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d input transactions over %0d length settings, with drain pauses",
			items_sent, N_SETTINGS + 1);
		$display("and a long result hold-off; %0d results (good %0d, length %0d, checksum %0d, truncated %0d).",
			sb.results_seen, sb.status_seen[ST_GOOD], sb.status_seen[ST_LEN],
			sb.status_seen[ST_CSUM], sb.status_seen[ST_TRUNC]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("Errors: %0d, results still expected: %0d.", sb.errors, sb.pending());
			$display("status: fail");
		end
		$finish;
	end

endmodule
